// ----- sv/ilir_pkg.sv -----
// Shared types and constants for the indexed list with insert and remove.
package ilir_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  localparam int unsigned POS_W    = 10;
  localparam int unsigned VAL_IO_W = 32;
  localparam int unsigned CNT_IO_W = 11;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STS_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_POP    = 3'd3,
    REQ_READ   = 3'd4,
    REQ_WRITE  = 3'd5
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } sts_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic     apply;
    cell_op_e op;
  } cell_cmd_t;

endpackage

// ----- sv/ilir_cell.sv -----
// One storage cell of the list: holds one entry and one stage of the read-out chain.
module ilir_cell #(
  parameter int unsigned VALUE_BITS = ilir_pkg::VALUE_BITS_DEF,
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                   clk_i,
  input  ilir_pkg::cell_cmd_t    cmd_i,
  input  logic [IDX_W-1:0]       pos_i,
  input  logic [VALUE_BITS-1:0]  val_i,
  input  logic [VALUE_BITS-1:0]  left_i,
  input  logic [VALUE_BITS-1:0]  right_i,
  input  logic [VALUE_BITS-1:0]  rd_next_i,
  output logic [VALUE_BITS-1:0]  entry_o,
  output logic [VALUE_BITS-1:0]  rd_o
);
  import ilir_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [VALUE_BITS-1:0] entry_q;
  logic [VALUE_BITS-1:0] rd_q;
  logic                  hit;
  logic                  above;

  assign hit   = (pos_i == MyIdx);
  assign above = (MyIdx > pos_i);

  always_ff @(posedge clk_i) begin
    // The read-out chain passes the selected entry down toward cell zero.
    rd_q <= hit ? entry_q : rd_next_i;
    if (cmd_i.apply) begin
      case (cmd_i.op)
        OP_WRITE: begin
          if (hit) entry_q <= val_i;
        end
        OP_INSERT: begin
          if (hit) entry_q <= val_i;
          else if (above) entry_q <= left_i;
        end
        OP_REMOVE: begin
          if (hit || above) entry_q <= right_i;
        end
        default: ;
      endcase
    end
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

// ----- sv/indexed_list_insert_remove.sv -----
// Indexed list of signed values with append, insert, remove, pop, read and write.
// The list lives in a row of MAX_ENTRIES cells, one entry per cell. An accepted
// request word first sweeps the read-out chain, which passes the addressed entry
// down toward cell zero through one register per cell; during that sweep the
// shrunk capacity is found by doubling one step per cycle. The request then waits
// in the finish state until the output register is empty or its waiting result
// word is taken; the new result word is then registered there, and in that same
// cycle all cells act: an insert moves every entry at or above the index up by
// one, a remove moves every entry above the index down by one. A new request word
// is taken only while no request is in flight, but a finished result word may
// still wait in the output register when the next request arrives.
// Capacity starts at 1, doubles when an append or insert finds the list full, and
// after a removal that leaves the length below a quarter of the capacity it drops
// to the next power of two at or above the length. Bad indexes and a full store
// change nothing and are reported in status; value_out is zero unless a value was
// read, removed or popped. There is no clearing pass after reset.
module indexed_list_insert_remove #(
  parameter int unsigned MAX_ENTRIES = ilir_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned VALUE_BITS  = ilir_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ilir_pkg::REQ_W-1:0]          req_type_i,
  input  logic [ilir_pkg::POS_W-1:0]          position_i,
  input  logic signed [ilir_pkg::VAL_IO_W-1:0] value_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ilir_pkg::VAL_IO_W-1:0] value_out_o,
  output logic [ilir_pkg::CNT_IO_W-1:0]       length_now_o,
  output logic [ilir_pkg::CNT_IO_W-1:0]       capacity_now_o,
  output logic [ilir_pkg::STS_W-1:0]          status_o
);
  import ilir_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CAP_W = CNT_W + 1;
  localparam int unsigned AW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Architectural state.
  logic [CNT_W-1:0] len_q;
  logic [CAP_W-1:0] cap_q;

  // The request in flight.
  cell_op_e               op_q;
  logic [IDX_W-1:0]       pos_q;
  logic [VALUE_BITS-1:0]  val_q;
  logic                   rd_en_q;
  sts_e                   sts_q;
  logic [CNT_W-1:0]       new_len_q;
  logic                   grow_q;
  logic                   may_shrink_q;
  logic [CAP_W-1:0]       pow_q;
  logic [IDX_W-1:0]       sweep_cnt_q;

  // Result register.
  logic                          out_valid_q;
  logic signed [VAL_IO_W-1:0]    value_out_q;
  logic [CNT_IO_W-1:0]           length_now_q;
  logic [CNT_IO_W-1:0]           capacity_now_q;
  sts_e                          status_q;

  // Request decode, evaluated on the accepted word.
  logic [AW-1:0]    pos_ext;
  logic [AW-1:0]    len_ext;
  logic             full;
  cell_op_e         dec_op;
  logic [AW-1:0]    dec_pos;
  logic             dec_rd;
  sts_e             dec_sts;
  logic [CNT_W-1:0] dec_len;
  logic             dec_grow;
  logic             dec_shrink;

  assign pos_ext = AW'(position_i);
  assign len_ext = AW'(len_q);
  assign full    = (len_q >= CNT_W'(MAX_ENTRIES));

  always_comb begin
    dec_op     = OP_HOLD;
    dec_pos    = pos_ext;
    dec_rd     = 1'b0;
    dec_sts    = STS_OK;
    dec_len    = len_q;
    dec_grow   = 1'b0;
    dec_shrink = 1'b0;
    unique case (req_type_i)
      REQ_APPEND: begin
        if (full) begin
          dec_sts = STS_FULL;
        end else begin
          dec_op   = OP_WRITE;
          dec_pos  = len_ext;
          dec_len  = len_q + CNT_W'(1);
          dec_grow = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_ext > len_ext) begin
          dec_sts = STS_RANGE;
        end else if (full) begin
          dec_sts = STS_FULL;
        end else begin
          dec_op   = OP_INSERT;
          dec_len  = len_q + CNT_W'(1);
          dec_grow = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_ext >= len_ext) begin
          dec_sts = STS_RANGE;
        end else begin
          dec_op     = OP_REMOVE;
          dec_rd     = 1'b1;
          dec_len    = len_q - CNT_W'(1);
          dec_shrink = 1'b1;
        end
      end
      REQ_POP: begin
        if (len_q == '0) begin
          dec_sts = STS_RANGE;
        end else begin
          dec_op     = OP_REMOVE;
          dec_pos    = len_ext - AW'(1);
          dec_rd     = 1'b1;
          dec_len    = len_q - CNT_W'(1);
          dec_shrink = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_ext >= len_ext) dec_sts = STS_RANGE;
        else dec_rd = 1'b1;
      end
      REQ_WRITE: begin
        if (pos_ext >= len_ext) dec_sts = STS_RANGE;
        else dec_op = OP_WRITE;
      end
      default: dec_sts = STS_RANGE;
    endcase
  end

  // Capacity after the request.
  logic             finish;
  logic [CAP_W-1:0] cap_d;
  logic             sparse;

  assign finish = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign sparse = ({new_len_q, 2'b00} < (CNT_W + 2)'(cap_q));

  always_comb begin
    cap_d = cap_q;
    if (grow_q && (CAP_W'(len_q) >= cap_q)) cap_d = cap_q << 1;
    else if (may_shrink_q && sparse) cap_d = pow_q;
  end

  // The cell row.
  cell_cmd_t             cmd;
  logic [VALUE_BITS-1:0] entry [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] rd    [MAX_ENTRIES];
  logic signed [VALUE_BITS-1:0] rd_head;

  assign cmd.apply = finish;
  assign cmd.op    = op_q;
  assign rd_head   = rd[0];

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [VALUE_BITS-1:0] left;
    logic [VALUE_BITS-1:0] right;
    logic [VALUE_BITS-1:0] rd_next;

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_left
      assign left = entry[k-1];
    end

    if (k == MAX_ENTRIES - 1) begin : g_last
      assign right   = '0;
      assign rd_next = '0;
    end else begin : g_mid_right
      assign right   = entry[k+1];
      assign rd_next = rd[k+1];
    end

    ilir_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .pos_i     (pos_q),
      .val_i     (val_q),
      .left_i    (left),
      .right_i   (right),
      .rd_next_i (rd_next),
      .entry_o   (entry[k]),
      .rd_o      (rd[k])
    );
  end

  // Sequencer: accept, sweep the read-out chain, then apply and post the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      len_q          <= '0;
      cap_q          <= CAP_W'(1);
      out_valid_q    <= 1'b0;
      op_q           <= OP_HOLD;
      sweep_cnt_q    <= '0;
      sts_q          <= STS_OK;
      status_q       <= STS_OK;
    end else begin
      // A new result word takes the output register; otherwise an accepted one leaves it.
      if (finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q         <= dec_op;
            pos_q        <= dec_pos[IDX_W-1:0];
            val_q        <= VALUE_BITS'(value_in_i);
            rd_en_q      <= dec_rd;
            sts_q        <= dec_sts;
            new_len_q    <= dec_len;
            grow_q       <= dec_grow;
            may_shrink_q <= dec_shrink;
            pow_q        <= CAP_W'(1);
            sweep_cnt_q  <= '0;
            state_q      <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          // Next power of two at or above the new length, one doubling a cycle.
          if (CAP_W'(new_len_q) > pow_q) pow_q <= pow_q << 1;
          sweep_cnt_q <= sweep_cnt_q + IDX_W'(1);
          if (sweep_cnt_q == IDX_W'(MAX_ENTRIES - 1)) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish) begin
            len_q          <= new_len_q;
            cap_q          <= cap_d;
            value_out_q    <= rd_en_q ? VAL_IO_W'(rd_head) : '0;
            length_now_q   <= CNT_IO_W'(new_len_q);
            capacity_now_q <= CNT_IO_W'(cap_d);
            status_q       <= sts_q;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign value_out_o    = value_out_q;
  assign length_now_o   = length_now_q;
  assign capacity_now_o = capacity_now_q;
  assign status_o       = status_q;

endmodule
